### src/bda_pkg.sv
// Package for the button debounce and auto-repeat block.
// Shared types, register indexes and sizing constants; no dependencies.
package bda_pkg;

    // Number of key channels handled per tick (1 to 32)
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Physical pin word and fixed field widths
    localparam int PIN_W   = 8;
    localparam int CHAN_W  = 3;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int IVL_W   = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RPT_FIRST  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RPT_SECOND = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RPT_PERIOD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_POLARITY   = 3'd4;

    // Output word: 87 bits of fields, padded to 88
    localparam int OUT_W = 88;

    // Auto-repeat stage
    typedef enum logic [1:0] {
        STG_FIRST  = 2'd0,
        STG_SECOND = 2'd1,
        STG_PERIOD = 2'd2
    } t_rpt_stage;

    // Per-channel state record
    typedef struct packed {
        logic              raw_prev;
        logic [TIME_W-1:0] stable_since;
        logic              pressed;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] release_start;
        t_rpt_stage        stage;
        logic [TIME_W-1:0] repeat_mark;
        logic [CNT_W-1:0]  press_tally;
        logic [CNT_W-1:0]  release_tally;
        logic [CNT_W-1:0]  repeat_tally;
    } t_chan_state;

    // Timing configuration seen by the update unit
    typedef struct packed {
        logic [IVL_W-1:0] debounce;
        logic [IVL_W-1:0] rpt_first;
        logic [IVL_W-1:0] rpt_second;
        logic [IVL_W-1:0] rpt_period;
    } t_timing_cfg;

    // Per-channel result fields
    typedef struct packed {
        logic              level;
        logic              press_edge;
        logic              release_edge;
        logic              repeat_edge;
        logic [CNT_W-1:0]  press_total;
        logic [CNT_W-1:0]  release_total;
        logic [CNT_W-1:0]  repeat_total;
        logic [TIME_W-1:0] held_ticks;
    } t_chan_result;

endpackage

### src/bda_chan_unit.sv
// Shared per-channel update unit: debounce, edge detection and auto-repeat.
// Purely combinational; used once per channel by the sequencer. Uses bda_pkg.
module bda_chan_unit (
    input  bda_pkg::t_chan_state  i_state,
    input  logic                  i_reading,
    input  logic [31:0]           i_cur,
    input  bda_pkg::t_timing_cfg  i_cfg,
    output bda_pkg::t_chan_state  o_state,
    output bda_pkg::t_chan_result o_result
);
    import bda_pkg::*;

    t_chan_state       s_deb;
    t_chan_state       s_rpt;
    logic [TIME_W-1:0] stable_age;
    logic [TIME_W-1:0] mark_age;
    logic [TIME_W-1:0] start_sel;
    logic [IVL_W-1:0]  ivl;
    logic              pe;
    logic              re;
    logic              rp;

    // Debounce and press/release acceptance
    always_comb begin
        s_deb = i_state;
        pe    = 1'b0;
        re    = 1'b0;
        if (i_reading != i_state.raw_prev) begin
            s_deb.raw_prev     = i_reading;
            s_deb.stable_since = i_cur;
        end
        stable_age = i_cur - s_deb.stable_since;
        if (stable_age >= TIME_W'(i_cfg.debounce)) begin
            if (i_reading && !i_state.pressed) begin
                s_deb.pressed     = 1'b1;
                s_deb.press_start = i_cur;
                s_deb.stage       = STG_FIRST;
                s_deb.repeat_mark = i_cur;
                s_deb.press_tally = i_state.press_tally + CNT_W'(1);
                pe                = 1'b1;
            end else if (!i_reading && i_state.pressed) begin
                s_deb.pressed       = 1'b0;
                s_deb.release_start = i_cur;
                s_deb.stage         = STG_FIRST;
                s_deb.release_tally = i_state.release_tally + CNT_W'(1);
                re                  = 1'b1;
            end
        end
    end

    // Auto-repeat while held
    always_comb begin
        s_rpt = s_deb;
        rp    = 1'b0;
        unique case (s_deb.stage)
            STG_FIRST:  ivl = i_cfg.rpt_first;
            STG_SECOND: ivl = i_cfg.rpt_second;
            STG_PERIOD: ivl = i_cfg.rpt_period;
            default:    ivl = i_cfg.rpt_period;
        endcase
        mark_age = i_cur - s_deb.repeat_mark;
        if (s_deb.pressed && (ivl != '0) && (mark_age >= TIME_W'(ivl))) begin
            s_rpt.repeat_mark  = i_cur;
            s_rpt.repeat_tally = s_deb.repeat_tally + CNT_W'(1);
            rp                 = 1'b1;
            unique case (s_deb.stage)
                STG_FIRST:  s_rpt.stage = STG_SECOND;
                STG_SECOND: s_rpt.stage = STG_PERIOD;
                STG_PERIOD: s_rpt.stage = STG_PERIOD;
                default:    s_rpt.stage = STG_PERIOD;
            endcase
        end
    end

    // Result fields
    assign start_sel = s_rpt.pressed ? s_rpt.press_start : s_rpt.release_start;
    assign o_state   = s_rpt;

    always_comb begin
        o_result.level         = s_rpt.pressed;
        o_result.press_edge    = pe;
        o_result.release_edge  = re;
        o_result.repeat_edge   = rp;
        o_result.press_total   = s_rpt.press_tally;
        o_result.release_total = s_rpt.release_tally;
        o_result.repeat_total  = s_rpt.repeat_tally;
        o_result.held_ticks    = i_cur - start_sel;
    end

endmodule

### src/bda_state_bank.sv
// Per-channel state store: one record per channel, read and written at the
// channel the sequencer is working on. Uses bda_pkg.
module bda_state_bank (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bda_pkg::CH_IDX_W-1:0]   i_idx,
    input  logic                           i_we,
    input  bda_pkg::t_chan_state           i_wr_state,
    output bda_pkg::t_chan_state           o_rd_state
);
    import bda_pkg::*;

    t_chan_state r_bank [CHANNELS];

    // Write back the updated record; reset clears every channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_bank[k] <= '0;
            end
        end else if (i_we) begin
            r_bank[i_idx] <= i_wr_state;
        end
    end

    assign o_rd_state = r_bank[i_idx];

endmodule

### src/button_debounce_autorepeat.sv
// Button debounce with three-stage auto-repeat: top level.
// Holds the configuration registers, the channel sequencer and the output
// register. Uses bda_pkg, bda_state_bank and bda_chan_unit.
//
// Each accepted input word is one millisecond tick carrying the raw pin levels.
// The block then walks the channels in order, one per clock cycle unless the
// output register is full and not taken, through a single shared update unit,
// and emits one output word per channel with tlast on the final channel.
// Each tick word is taken in idle, then each channel goes through the update
// unit in turn. The input is ready only between ticks, so a new word is not
// taken until the final channel of the previous tick has been stepped.
// Configuration writes are meant for idle periods and take effect at once.
module button_debounce_autorepeat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bda_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bda_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] pin_levels
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] channel, [3] level, [4] press_edge, [5] release_edge,
    // [6] repeat_edge, [22:7] press_total, [38:23] release_total,
    // [54:39] repeat_total, [86:55] held_ticks, [87] zero pad
    output logic [bda_pkg::OUT_W-1:0]       m_axis_tdata,
    output logic                            m_axis_tlast   // last_channel
);
    import bda_pkg::*;

    localparam int IDX_XW = CH_IDX_W + CHAN_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    t_seq_state           r_state;
    logic [CH_IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0]    r_tick;
    logic [PIN_W-1:0]     r_pins;
    t_timing_cfg          r_cfg;
    logic [PIN_W-1:0]     r_polarity;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic                 r_out_last;

    t_chan_state          cur_state;
    t_chan_state          upd_state;
    t_chan_result         res;
    logic [IDX_XW-1:0]    idx_x;
    logic                 pin_bit;
    logic                 pol_bit;
    logic                 reading;
    logic                 advance;
    logic                 at_last;
    logic                 in_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= IVL_W'(10);
            r_cfg.rpt_first  <= IVL_W'(60);
            r_cfg.rpt_second <= IVL_W'(250);
            r_cfg.rpt_period <= IVL_W'(200);
            r_polarity       <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data;
                REG_RPT_FIRST:  r_cfg.rpt_first  <= i_cfg_data;
                REG_RPT_SECOND: r_cfg.rpt_second <= i_cfg_data;
                REG_RPT_PERIOD: r_cfg.rpt_period <= i_cfg_data;
                REG_POLARITY:   r_polarity       <= i_cfg_data[PIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pressed reading of the current channel; channels past the pin word read as pressed
    assign idx_x   = IDX_XW'(r_idx);
    assign pin_bit = (idx_x < IDX_XW'(PIN_W)) ? r_pins[idx_x[CHAN_W-1:0]] : 1'b0;
    assign pol_bit = (idx_x < IDX_XW'(PIN_W)) ? r_polarity[idx_x[CHAN_W-1:0]] : 1'b0;
    assign reading = (pin_bit == pol_bit);

    assign in_take = s_axis_tvalid && s_axis_tready;
    assign advance = (r_state == ST_RUN) && (!r_out_valid || m_axis_tready);
    assign at_last = (r_idx == CH_IDX_W'(CHANNELS - 1));

    bda_state_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_idx      (r_idx),
        .i_we       (advance),
        .i_wr_state (upd_state),
        .o_rd_state (cur_state)
    );

    bda_chan_unit u_unit (
        .i_state  (cur_state),
        .i_reading(reading),
        .i_cur    (r_tick),
        .i_cfg    (r_cfg),
        .o_state  (upd_state),
        .o_result (res)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new word loads on advance, otherwise a taken word empties the register
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_pins  <= s_axis_tdata;
                        r_idx   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (advance) begin
                        r_out_last  <= at_last;
                        r_out_data  <= {1'b0, res.held_ticks, res.repeat_total,
                                        res.release_total, res.press_total,
                                        res.repeat_edge, res.release_edge,
                                        res.press_edge, res.level,
                                        idx_x[CHAN_W-1:0]};
                        if (at_last) begin
                            r_idx   <= '0;
                            r_tick  <= r_tick + TIME_W'(1);
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + CH_IDX_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !s_axis_tready)
        else $error("input ready again right after a tick was taken");

    a_last_is_final_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == CHAN_W'(CHANNELS - 1)))
        else $error("tlast on a word that is not the final channel");

    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]))
        else $error("press and release accepted in the same tick");

    a_repeat_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> m_axis_tdata[3])
        else $error("repeat event on a released channel");

    a_tick_steps_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && at_last) |=> (r_tick == $past(r_tick) + TIME_W'(1)))
        else $error("tick counter did not advance at end of tick");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for button_debounce_autorepeat: pin-level ticks go in with random gaps and
// back-pressure, and every per-channel report is checked against a key model.
// Depends on bda_pkg and the block's RTL.
module testbench;
    import bda_pkg::*;

    localparam int     RST_CYCLES   = 9;
    localparam int     REPORT_CAP   = 100;           // mismatch lines printed at most
    localparam int     DRAIN_CYCLES = CHANNELS + 4;  // one tick walk plus margin
    localparam int     PHASES       = 8;
    localparam int     PHASE_TICKS  = 35;
    localparam int     BURST_TICKS  = 16;            // back-to-back ticks, one repeat each once held
    localparam longint TIMEOUT_NS   = 5_000_000;

    // One expected report, as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        t_chan_result      res;
        logic              last;
    } t_key_report;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] pin_levels
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] channel, [3] level, [4] press_edge, [5] release_edge, [6] repeat_edge,
    // [22:7] press_total, [38:23] release_total, [54:39] repeat_total, [86:55] held_ticks
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;         // last_channel

    // Key model: configuration and per-channel state
    t_timing_cfg       timing = '{debounce: 16'd10, rpt_first: 16'd60,
                                  rpt_second: 16'd250, rpt_period: 16'd200};
    logic [PIN_W-1:0]  polarity = 8'hFF;
    logic [TIME_W-1:0] tick_count = '0;
    logic              raw_seen    [CHANNELS] = '{default: 1'b0};
    logic [TIME_W-1:0] steady_from [CHANNELS] = '{default: '0};
    logic              key_down    [CHANNELS] = '{default: 1'b0};
    logic [TIME_W-1:0] down_at     [CHANNELS] = '{default: '0};
    logic [TIME_W-1:0] up_at       [CHANNELS] = '{default: '0};
    t_rpt_stage        stage       [CHANNELS] = '{default: STG_FIRST};
    logic [TIME_W-1:0] repeat_at   [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0]  presses     [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0]  releases    [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0]  repeats     [CHANNELS] = '{default: '0};

    t_key_report pending_reports[$];
    int          mismatches = 0;
    bit          quiet_link = 1'b0;   // no idling on either side while set
    int          rx_hold    = 0;

    button_debounce_autorepeat dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Advance the key model by one tick and queue the report of every channel
    function automatic void debounce_tick(logic [PIN_W-1:0] pins);
        logic [TIME_W-1:0] now_t;
        logic              rd;
        logic [IVL_W-1:0]  ivl;
        t_key_report       rep;
        now_t = tick_count;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            // pins and polarity beyond the pin word both read as zero
            rd  = (ch < PIN_W) ? (pins[ch] == polarity[ch]) : 1'b1;
            rep = '0;
            if (rd != raw_seen[ch]) begin
                raw_seen[ch]    = rd;
                steady_from[ch] = now_t;
            end
            // debounce: accept once the reading has been steady long enough
            if ((now_t - steady_from[ch]) >= timing.debounce) begin
                if (rd && !key_down[ch]) begin
                    key_down[ch]  = 1'b1;
                    down_at[ch]   = now_t;
                    repeat_at[ch] = now_t;
                    stage[ch]     = STG_FIRST;
                    presses[ch]   = presses[ch] + 1'b1;
                    rep.res.press_edge = 1'b1;
                end else if (!rd && key_down[ch]) begin
                    key_down[ch] = 1'b0;
                    up_at[ch]    = now_t;
                    stage[ch]    = STG_FIRST;
                    releases[ch] = releases[ch] + 1'b1;
                    rep.res.release_edge = 1'b1;
                end
            end
            // auto-repeat while held; a zero interval parks the stage
            if (key_down[ch]) begin
                case (stage[ch])
                    STG_FIRST:  ivl = timing.rpt_first;
                    STG_SECOND: ivl = timing.rpt_second;
                    default:    ivl = timing.rpt_period;
                endcase
                if ((ivl != '0) && ((now_t - repeat_at[ch]) >= ivl)) begin
                    repeat_at[ch] = now_t;
                    stage[ch]     = (stage[ch] == STG_FIRST) ? STG_SECOND : STG_PERIOD;
                    repeats[ch]   = repeats[ch] + 1'b1;
                    rep.res.repeat_edge = 1'b1;
                end
                rep.res.held_ticks = now_t - down_at[ch];
            end else begin
                rep.res.held_ticks = now_t - up_at[ch];
            end
            rep.channel             = ch[CHAN_W-1:0];
            rep.res.level           = key_down[ch];
            rep.res.press_total     = presses[ch];
            rep.res.release_total   = releases[ch];
            rep.res.repeat_total    = repeats[ch];
            rep.last                = (ch == CHANNELS - 1);
            pending_reports.push_back(rep);
        end
        tick_count = now_t + 1'b1;
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Output side: random back-pressure
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet_link && $urandom_range(0, 3) == 0) begin
            rx_hold       <= idle_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Each accepted report word against the oldest expectation
    always @(posedge i_clk) begin : report_check
        t_key_report want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("unexpected report word for channel %0d", m_axis_tdata[2:0]);
            end else begin
                want = pending_reports.pop_front();
                check_field("channel",       want.channel,           m_axis_tdata[2:0]);
                check_field("level",         want.res.level,         m_axis_tdata[3]);
                check_field("press_edge",    want.res.press_edge,    m_axis_tdata[4]);
                check_field("release_edge",  want.res.release_edge,  m_axis_tdata[5]);
                check_field("repeat_edge",   want.res.repeat_edge,   m_axis_tdata[6]);
                check_field("press_total",   want.res.press_total,   m_axis_tdata[22:7]);
                check_field("release_total", want.res.release_total, m_axis_tdata[38:23]);
                check_field("repeat_total",  want.res.repeat_total,  m_axis_tdata[54:39]);
                check_field("held_ticks",    want.res.held_ticks,    m_axis_tdata[86:55]);
                check_field("last_channel",  want.last,              m_axis_tlast);
            end
        end
    end

    // Send one tick word; valid stays high when no gap follows
    task automatic send_pins(logic [PIN_W-1:0] pins);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pins;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        debounce_tick(pins);
        gap = quiet_link ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input off until every expected report has come out
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE:   timing.debounce   = val;
            REG_RPT_FIRST:  timing.rpt_first  = val;
            REG_RPT_SECOND: timing.rpt_second = val;
            REG_RPT_PERIOD: timing.rpt_period = val;
            REG_POLARITY:   polarity          = val[PIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_timing(logic [IVL_W-1:0] deb, logic [IVL_W-1:0] first,
                                  logic [IVL_W-1:0] second, logic [IVL_W-1:0] period,
                                  logic [PIN_W-1:0] pol);
        logic [31:0]                 rnd;
        logic [CFG_DATA_W-PIN_W-1:0] junk;
        rnd  = $urandom;
        junk = rnd[CFG_DATA_W-PIN_W-1:0];   // upper bits of the polarity write must be dropped
        write_reg(REG_DEBOUNCE,   deb);
        write_reg(REG_RPT_FIRST,  first);
        write_reg(REG_RPT_SECOND, second);
        write_reg(REG_RPT_PERIOD, period);
        write_reg(REG_POLARITY,   {junk, pol});
    endtask

    // Reset values: all keys held until the default debounce accepts them
    task automatic test_reset_defaults();
        repeat (11) send_pins(8'hFF);
    endtask

    // Zero debounce takes a change in the same tick; mixed polarity
    task automatic test_zero_debounce();
        drain_reports();
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_POLARITY, 16'hC30F);
        send_pins(8'h00);
        send_pins(8'hFF);
        send_pins(8'hA5);
    endtask

    // First, second and period stages, then the stage stays at period
    task automatic test_repeat_stages();
        drain_reports();
        write_reg(REG_POLARITY,   16'h00FF);
        write_reg(REG_RPT_FIRST,  16'd1);
        write_reg(REG_RPT_SECOND, 16'd2);
        write_reg(REG_RPT_PERIOD, 16'd1);
        send_pins(8'h00);
        repeat (6) send_pins(8'hFF);
    endtask

    // A zero second interval stops repeats after the first one
    task automatic test_disabled_stage();
        drain_reports();
        write_reg(REG_RPT_SECOND, '0);
        send_pins(8'h00);
        repeat (3) send_pins(8'hFF);
    endtask

    // Writes above the last register must change nothing
    task automatic test_spare_registers();
        drain_reports();
        for (int a = REG_POLARITY + 1; a < 2 ** CFG_ADDR_W; a++)
            write_reg(CFG_ADDR_W'(a), '1);
    endtask

    // Held and released keys with contact bounce, plus some pure noise
    task automatic test_random_traffic();
        logic [PIN_W-1:0] intent;
        logic [PIN_W-1:0] noise;
        int               flip_pct;
        int               bounce_pct;
        int               pick;
        intent = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_reports();
            quiet_link = (ph == 0) || ($urandom_range(0, 3) == 0);
            case (ph)
                0:       program_timing(16'd2, 16'd3, 16'd2, 16'd1, PIN_W'($urandom));
                1:       program_timing('1, '1, '1, '1, 8'h00);
                2:       program_timing('0, 16'd1, 16'd1, 16'd1, 8'hFF);
                default: program_timing(IVL_W'($urandom_range(0, 4)),
                                        IVL_W'($urandom_range(0, 6)),
                                        IVL_W'($urandom_range(0, 6)),
                                        IVL_W'($urandom_range(0, 6)),
                                        PIN_W'($urandom));
            endcase
            flip_pct   = $urandom_range(10, 35);
            bounce_pct = $urandom_range(0, 25);
            for (int t = 0; t < PHASE_TICKS; t++) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_pins(PIN_W'($urandom));
                end else begin
                    if ($urandom_range(0, 99) < flip_pct) begin
                        pick         = $urandom_range(0, PIN_W - 1);
                        intent[pick] = ~intent[pick];
                    end
                    noise = ($urandom_range(0, 99) < bounce_pct) ?
                            PIN_W'($urandom & $urandom) : '0;
                    send_pins(intent ^ noise);
                end
            end
        end
        quiet_link = 1'b0;
    endtask

    // Ticks back to back with no idling, one repeat per tick on every channel once held
    task automatic test_back_to_back();
        drain_reports();
        quiet_link = 1'b1;
        program_timing('0, 16'd1, 16'd1, 16'd1, 8'hFF);
        repeat (BURST_TICKS) send_pins(8'hFF);
        quiet_link = 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_debounce();
        test_repeat_stages();
        test_disabled_stage();
        test_spare_registers();
        test_random_traffic();
        test_back_to_back();
        drain_reports();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
